FILE: design/bdbs_pkg.sv
// Shared types and codes for the banked cartridge bus decoder.
package bdbs_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'b00,
    OP_WRITE = 2'b01,
    OP_LOAD  = 2'b10,
    OP_NONE  = 2'b11
  } op_t;

  typedef enum logic [2:0] {
    TGT_ROM   = 3'd0,
    TGT_VIDEO = 3'd1,
    TGT_RAM   = 3'd2,
    TGT_IO    = 3'd3,
    TGT_NONE  = 3'd4,
    TGT_LOAD  = 3'd5
  } target_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
    logic [12:0] load_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [7:0]  read_data;
    logic [12:0] chip_offset;
    logic        current_bank;
  } out_item_t;

  localparam logic [13:0] SWITCH_SIZE  = 14'd8192;
  localparam logic [13:0] BANK_BYTES   = 14'd4096;
  localparam int          RAM_BYTES    = 128;
  localparam logic [12:0] HOTSPOT_LOW  = 13'h1FF8;
  localparam logic [12:0] HOTSPOT_HIGH = 13'h1FF9;
  localparam logic [7:0]  EMPTY_BYTE   = 8'hFF;

  localparam logic [2:0]  REG_ROM_SIZE = 3'd0;

endpackage

FILE: design/bus_decoder_with_bank_switching_core.sv
// Bus decoder with two-bank cartridge switching, ROM and RAM kept in memories.
// A ROM read that needs the offset reduced modulo a ROM size below 4096 first passes
// through S_MOD (one remainder bit per cycle) before S_RD; other items go straight
// to S_RD, where the result is registered. A stalled result holds off the next beat.
// One item at a time: the input stalls until the result of the last one is loaded.
// Reset: rom_size 0, bank 1, all 128 RAM valid bits cleared;
// ROM contents are undefined until loaded.
module bus_decoder_with_bank_switching_core #(
  parameter int ROM_BYTES = 8192
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bdbs_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bdbs_pkg::out_item_t   out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int          AW        = $clog2(ROM_BYTES);
  localparam logic [13:0] ROM_LIMIT = 14'(ROM_BYTES);
  localparam logic        REG_IDX0  = bdbs_pkg::REG_ROM_SIZE[0];

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MOD  = 3'b010,
    S_RD   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [13:0] rom_size_r, rom_size_nxt;
  logic        bank_r, bank_nxt;
  logic [bdbs_pkg::RAM_BYTES-1:0] ram_vld_r, ram_vld_nxt;

  logic        out_valid_r, out_valid_nxt;
  bdbs_pkg::out_item_t out_data_r;

  // Per-item payload captured at acceptance.
  logic [2:0]  tgt_r;
  logic        is_read_r;
  logic        empty_r;
  logic [12:0] offs_r;

  // Modulo unit.
  logic [11:0] rem_r, off_r;
  logic [3:0]  cnt_r;
  logic [12:0] rem_sh, rem_step;

  logic [7:0]  rom_mem [ROM_BYTES];
  logic [7:0]  ram_mem [bdbs_pkg::RAM_BYTES];
  logic [7:0]  rom_q_r, ram_q_r;
  logic        ram_hit_r;

  logic        accept, cfg_wr;
  logic [13:0] eff_size;
  logic        switching, empty;
  logic [12:0] bus;
  logic        is_bus, is_rd, rom_hit, video_hit, ram_hit, io_hit;
  logic        need_mod, bank_new;
  logic [2:0]  tgt_in;
  logic [12:0] offs_in;
  logic        rom_wr_en, rom_rd_en, ram_wr_en, ram_rd_en;
  logic [AW-1:0] rom_rd_addr;
  logic [12:0] rom_idx;
  logic [6:0]  ram_addr;
  logic        out_load;
  logic [7:0]  rd_byte;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_pready = 1'b1;
  assign cfg_wr    = cfg_psel && cfg_penable && cfg_pwrite &&
                     (cfg_paddr[2] == REG_IDX0);
  assign cfg_prdata = (cfg_paddr[2] == REG_IDX0) ? {18'd0, rom_size_r} : 32'd0;

  assign eff_size  = (rom_size_r > ROM_LIMIT) ? ROM_LIMIT : rom_size_r;
  assign switching = (eff_size == bdbs_pkg::SWITCH_SIZE);
  assign empty     = (eff_size == 14'd0);

  assign bus       = in_data.address[12:0];
  assign is_bus    = (in_data.operation == bdbs_pkg::OP_READ) ||
                     (in_data.operation == bdbs_pkg::OP_WRITE);
  assign is_rd     = (in_data.operation == bdbs_pkg::OP_READ);
  assign rom_hit   = is_bus && bus[12];
  assign video_hit = is_bus && !bus[12] && !bus[7];
  assign ram_hit   = is_bus && !bus[12] && bus[7] && !bus[9];
  assign io_hit    = is_bus && !bus[12] && bus[7] && bus[9];

  // Hotspot accesses, read or write, flip the bank before the fetch.
  always_comb begin
    bank_new = bank_r;
    if (rom_hit && switching) begin
      if (bus == bdbs_pkg::HOTSPOT_LOW) begin
        bank_new = 1'b0;
      end else if (bus == bdbs_pkg::HOTSPOT_HIGH) begin
        bank_new = 1'b1;
      end
    end
  end

  always_comb begin
    tgt_in  = bdbs_pkg::TGT_NONE;
    offs_in = 13'd0;
    if (in_data.operation == bdbs_pkg::OP_LOAD) begin
      tgt_in = bdbs_pkg::TGT_LOAD;
    end else if (rom_hit) begin
      tgt_in = bdbs_pkg::TGT_ROM;
    end else if (video_hit) begin
      tgt_in  = bdbs_pkg::TGT_VIDEO;
      offs_in = bus;
    end else if (ram_hit) begin
      tgt_in = bdbs_pkg::TGT_RAM;
    end else if (io_hit) begin
      tgt_in  = bdbs_pkg::TGT_IO;
      offs_in = bus;
    end
  end

  // Sizes of 4096 and up never wrap a 12-bit offset; only smaller ones need the divider.
  assign need_mod = is_rd && rom_hit && !empty && (eff_size < bdbs_pkg::BANK_BYTES);

  assign rem_sh   = {rem_r, off_r[cnt_r]};
  assign rem_step = (rem_sh >= eff_size[12:0]) ? (rem_sh - eff_size[12:0]) : rem_sh;

  always_comb begin
    rom_idx = switching ? {bank_new, bus[11:0]} : {1'b0, bus[11:0]};
    rom_rd_en   = 1'b0;
    rom_rd_addr = rom_idx[AW-1:0];
    if (accept && is_rd && rom_hit && !empty && !need_mod) begin
      rom_rd_en = 1'b1;
    end else if (state_r == S_MOD && cnt_r == 4'd0) begin
      rom_rd_en   = 1'b1;
      rom_rd_addr = AW'(rem_step);
    end
  end

  assign rom_wr_en = accept && (in_data.operation == bdbs_pkg::OP_LOAD) &&
                     ({1'b0, in_data.load_index} < ROM_LIMIT);
  assign ram_addr  = bus[6:0];
  assign ram_wr_en = accept && ram_hit && !is_rd;
  assign ram_rd_en = accept && ram_hit && is_rd;

  always_ff @(posedge clk) begin
    if (rom_wr_en) begin
      rom_mem[in_data.load_index[AW-1:0]] <= in_data.data;
    end
    if (rom_rd_en) begin
      rom_q_r <= rom_mem[rom_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ram_wr_en) begin
      ram_mem[ram_addr] <= in_data.data;
    end
    if (ram_rd_en) begin
      ram_q_r   <= ram_mem[ram_addr];
      ram_hit_r <= ram_vld_r[ram_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tgt_r     <= tgt_in;
      is_read_r <= is_rd;
      empty_r   <= empty;
      offs_r    <= offs_in;
      rem_r     <= 12'd0;
      off_r     <= bus[11:0];
      cnt_r     <= 4'd11;
    end else if (state_r == S_MOD) begin
      rem_r <= rem_step[11:0];
      cnt_r <= cnt_r - 4'd1;
    end
    if (out_load) begin
      out_data_r <= '{target: tgt_r, read_data: rd_byte,
                      chip_offset: offs_r, current_bank: bank_r};
    end
  end

  always_comb begin
    rd_byte = 8'd0;
    if (is_read_r && tgt_r == bdbs_pkg::TGT_ROM) begin
      rd_byte = empty_r ? bdbs_pkg::EMPTY_BYTE : rom_q_r;
    end else if (is_read_r && tgt_r == bdbs_pkg::TGT_RAM) begin
      rd_byte = ram_hit_r ? ram_q_r : 8'd0;
    end
  end

  assign out_load = (state_r == S_RD) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = need_mod ? S_MOD : S_RD;
        end
      end
      S_MOD: begin
        if (cnt_r == 4'd0) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    rom_size_nxt = rom_size_r;
    bank_nxt     = bank_r;
    ram_vld_nxt  = ram_vld_r;
    if (cfg_wr) begin
      rom_size_nxt = cfg_pwdata[13:0];
      // Writing the size re-arms the bank: upper bank if switching, else bank 0.
      bank_nxt = (((cfg_pwdata[13:0] > ROM_LIMIT) ? ROM_LIMIT : cfg_pwdata[13:0]) ==
                  bdbs_pkg::SWITCH_SIZE);
    end else if (accept) begin
      bank_nxt = bank_new;
    end
    if (ram_wr_en) begin
      ram_vld_nxt[ram_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rom_size_r  <= 14'd0;
      bank_r      <= 1'b1;
      ram_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rom_size_r  <= rom_size_nxt;
      bank_r      <= bank_nxt;
      ram_vld_r   <= ram_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/bdbs_checker.sv
// Port-level checker for the banked bus decoder, bound to the top level.
module bdbs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input bdbs_pkg::out_item_t out_data
);

  // A result held against a stall keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Items are worked one at a time, so an accepted beat closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // Only ROM and RAM accesses return data.
  a_data_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.target != bdbs_pkg::TGT_ROM &&
    out_data.target != bdbs_pkg::TGT_RAM |-> out_data.read_data == 8'd0)
    else $error("read data on a target without storage");

  // Only the two chips receive an offset.
  a_offset_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.target != bdbs_pkg::TGT_VIDEO &&
    out_data.target != bdbs_pkg::TGT_IO |-> out_data.chip_offset == 13'd0)
    else $error("chip offset on a non-chip target");

endmodule

bind bus_decoder_with_bank_switching_core bdbs_checker u_bdbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: bench/tb_top.sv
// Self-checking bench for the banked cartridge bus decoder: predicted bus results vs. the DUT.
`timescale 1ns / 100ps

module tb_top;

  localparam int ROM_DEPTH     = 8192;
  localparam int SETTLE_CYCLES = 20;

  typedef enum {STALL_NONE, STALL_SPARSE, STALL_ALTERNATE, STALL_HEAVY} stall_mode_t;

  // Mirrors the memory map and predicts one decode result per accepted access.
  class bus_map_checker;
    logic [7:0]  rom_bytes [ROM_DEPTH];
    bit          rom_loaded [ROM_DEPTH];
    logic [7:0]  ram_bytes [bdbs_pkg::RAM_BYTES];
    logic        bank;
    logic [13:0] size_reg;
    bdbs_pkg::out_item_t expected_results [$];
    int          failures;

    function new();
      foreach (ram_bytes[i]) ram_bytes[i] = '0;
      foreach (rom_loaded[i]) rom_loaded[i] = 1'b0;
      bank = 1'b1;
      size_reg = '0;
      failures = 0;
    endfunction

    function int unsigned eff_size();
      return (size_reg > bdbs_pkg::SWITCH_SIZE) ? bdbs_pkg::SWITCH_SIZE : size_reg;
    endfunction

    function void set_rom_size(logic [13:0] value);
      size_reg = value;
      bank = (eff_size() == bdbs_pkg::SWITCH_SIZE);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // ROM byte that a read would fetch, after any hotspot bank change; -1 if none.
    function int rom_read_index(bdbs_pkg::in_item_t it);
      logic [12:0] fold;
      logic        b;
      int unsigned sz;
      fold = it.address[12:0];
      sz = eff_size();
      if (it.operation != bdbs_pkg::OP_READ || !fold[12] || sz == 0) return -1;
      if (sz == bdbs_pkg::SWITCH_SIZE) begin
        b = bank;
        if (fold == bdbs_pkg::HOTSPOT_LOW) b = 1'b0;
        else if (fold == bdbs_pkg::HOTSPOT_HIGH) b = 1'b1;
        return int'({b, fold[11:0]});
      end
      return int'(fold[11:0] % sz);
    endfunction

    function void note_access(bdbs_pkg::in_item_t it);
      bdbs_pkg::out_item_t want;
      logic [12:0] fold;
      int          idx;
      fold = it.address[12:0];
      idx = rom_read_index(it);
      want = '0;
      case (it.operation)
        bdbs_pkg::OP_LOAD: begin
          rom_bytes[it.load_index] = it.data;
          rom_loaded[it.load_index] = 1'b1;
          want.target = bdbs_pkg::TGT_LOAD;
        end
        bdbs_pkg::OP_READ, bdbs_pkg::OP_WRITE: begin
          if (fold[12]) begin
            want.target = bdbs_pkg::TGT_ROM;
            if (eff_size() == bdbs_pkg::SWITCH_SIZE) begin
              if (fold == bdbs_pkg::HOTSPOT_LOW) bank = 1'b0;
              else if (fold == bdbs_pkg::HOTSPOT_HIGH) bank = 1'b1;
            end
            if (it.operation == bdbs_pkg::OP_READ)
              want.read_data = (idx < 0) ? bdbs_pkg::EMPTY_BYTE : rom_bytes[idx];
          end else if (!fold[7]) begin
            want.target = bdbs_pkg::TGT_VIDEO;
            want.chip_offset = fold;
          end else if (!fold[9]) begin
            // Bit 7 is set here, so bit 9 alone splits RAM from the I/O chip.
            want.target = bdbs_pkg::TGT_RAM;
            if (it.operation == bdbs_pkg::OP_READ) want.read_data = ram_bytes[fold[6:0]];
            else ram_bytes[fold[6:0]] = it.data;
          end else begin
            want.target = bdbs_pkg::TGT_IO;
            want.chip_offset = fold;
          end
        end
        default: want.target = bdbs_pkg::TGT_NONE;
      endcase
      want.current_bank = bank;
      expected_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s expected 0x%0h actual 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(bdbs_pkg::out_item_t got);
      bdbs_pkg::out_item_t want;
      if (expected_results.size() == 0) begin
        $error("result beat with no access outstanding");
        failures++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("target", want.target, got.target);
      compare_field("read_data", want.read_data, got.read_data);
      compare_field("chip_offset", want.chip_offset, got.chip_offset);
      compare_field("current_bank", want.current_bank, got.current_bank);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  bdbs_pkg::in_item_t  in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  bdbs_pkg::out_item_t out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bus_map_checker sb;
  int             burst_left = 0;
  bit             steady_sender = 1'b0;
  stall_mode_t    stall_mode = STALL_NONE;
  int             stall_left = 0;

  bus_decoder_with_bank_switching_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // The receiver switches at random between stall patterns.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(40, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:      out_stall <= 1'b0;
      STALL_SPARSE:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_ALTERNATE: out_stall <= ~out_stall;
      default:         out_stall <= ($urandom_range(0, 7) < 5);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Drives one beat, holds it until accepted, then closes the burst with a gap if due.
  task automatic issue(bdbs_pkg::op_t op, logic [15:0] addr, logic [7:0] value,
                       logic [12:0] lidx);
    bdbs_pkg::in_item_t it;
    int       idx;
    int       gap;
    it.operation = op;
    it.address = addr;
    it.data = value;
    it.load_index = lidx;
    idx = sb.rom_read_index(it);
    if (idx >= 0 && !sb.rom_loaded[idx]) begin
      // ROM bytes that were never loaded are never fetched, so load this one instead.
      it.operation = bdbs_pkg::OP_LOAD;
      it.load_index = 13'(idx);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_access(it);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = steady_sender ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes rom_size once the decoder is idle, then reads it back.
  task automatic program_rom_size(logic [13:0] size);
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {bdbs_pkg::REG_ROM_SIZE[0], 2'b00};
    cfg_pwdata <= 32'(size);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_rom_size(size);
    @(negedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[13:0] !== size) begin
      $error("rom_size readback expected 0x%0h actual 0x%0h", size, cfg_prdata[13:0]);
      sb.failures++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin
    int          sel;
    int unsigned sz;
    int unsigned span;
    logic [2:0]  hi;
    logic [12:0] fold;
    logic [12:0] li;
    bdbs_pkg::op_t op;
    logic [13:0] sizes [$];
    sb = new();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // No cartridge yet: ROM reads return the empty byte and hotspots do nothing.
    issue(bdbs_pkg::OP_READ, 16'h1000, 8'h00, 13'h0000);
    issue(bdbs_pkg::OP_READ, 16'hFFFF, 8'hFF, 13'h1FFF);
    issue(bdbs_pkg::OP_WRITE, 16'h1FF8, 8'hFF, 13'h0000);
    issue(bdbs_pkg::OP_READ, 16'h0000, 8'h00, 13'h0000);
    issue(bdbs_pkg::OP_WRITE, 16'h007F, 8'hFF, 13'h0000);
    issue(bdbs_pkg::OP_READ, 16'h0080, 8'h00, 13'h0000);
    issue(bdbs_pkg::OP_WRITE, 16'h00FF, 8'hFF, 13'h0000);
    issue(bdbs_pkg::OP_READ, 16'h00FF, 8'h00, 13'h0000);
    issue(bdbs_pkg::OP_READ, 16'h0280, 8'h00, 13'h0000);
    issue(bdbs_pkg::OP_WRITE, 16'hE2FF, 8'h5A, 13'h0000);
    issue(bdbs_pkg::OP_NONE, 16'hFFFF, 8'hFF, 13'h1FFF);
    issue(bdbs_pkg::OP_LOAD, 16'h0000, 8'hA5, 13'h0000);
    issue(bdbs_pkg::OP_LOAD, 16'hFFFF, 8'hFF, 13'h1FFF);
    issue(bdbs_pkg::OP_LOAD, 16'h0000, 8'h11, 13'h0FF8);
    issue(bdbs_pkg::OP_LOAD, 16'h0000, 8'h22, 13'h0FF9);
    issue(bdbs_pkg::OP_LOAD, 16'h0000, 8'h33, 13'h1FF8);
    issue(bdbs_pkg::OP_LOAD, 16'h0000, 8'h44, 13'h1FF9);
    issue(bdbs_pkg::OP_LOAD, 16'h0000, 8'h5A, 13'h0002);

    // Full-size cartridge: hotspot accesses flip the bank before the fetch.
    program_rom_size(bdbs_pkg::SWITCH_SIZE);
    issue(bdbs_pkg::OP_READ, 16'h1FF8, 8'h00, 13'h0000);
    issue(bdbs_pkg::OP_READ, 16'h1FF9, 8'h00, 13'h0000);
    issue(bdbs_pkg::OP_WRITE, 16'h1FF8, 8'h00, 13'h0000);
    issue(bdbs_pkg::OP_READ, 16'hFFF9, 8'h00, 13'h0000);

    // Tiny cartridge: reads wrap modulo the size.
    program_rom_size(14'd3);
    issue(bdbs_pkg::OP_LOAD, 16'h0000, 8'h77, 13'h0001);
    issue(bdbs_pkg::OP_READ, 16'h1005, 8'h00, 13'h0000);
    issue(bdbs_pkg::OP_READ, 16'h1FFF, 8'h00, 13'h0000);

    sizes = {14'd8192, 14'd1, 14'd4095, 14'd4096, 14'd100, 14'h3FFF, 14'd0, 14'd8191,
             14'd3, 14'd2048, 14'd8192, 14'($urandom_range(1, 8192))};
    foreach (sizes[p]) begin
      program_rom_size(sizes[p]);
      steady_sender = (p % 3 == 2);
      repeat (142) begin
        sel = $urandom_range(0, 99);
        op = (sel < 20) ? bdbs_pkg::OP_LOAD : (sel < 55) ? bdbs_pkg::OP_READ :
             (sel < 93) ? bdbs_pkg::OP_WRITE : bdbs_pkg::OP_NONE;
        hi = 3'($urandom);
        fold = 13'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
          fold[12] = 1'b1;
        end else if (sel < 40) begin
          fold = ($urandom_range(0, 1) != 0) ? bdbs_pkg::HOTSPOT_HIGH : bdbs_pkg::HOTSPOT_LOW;
        end else if (sel < 55) begin
          fold[12] = 1'b0;
          fold[9] = 1'b0;
          fold[7] = 1'b1;
        end else if (sel < 70) begin
          fold[12] = 1'b0;
          fold[7] = 1'b0;
        end else if (sel < 85) begin
          fold[12] = 1'b0;
          fold[9] = 1'b1;
          fold[7] = 1'b1;
        end
        // Small cartridges only ever fetch below their size, so aim most loads there.
        sz = sb.eff_size();
        span = (sz < 4096) ? sz : 4096;
        li = 13'($urandom);
        if (sz > 0 && sz < ROM_DEPTH && $urandom_range(0, 3) != 0)
          li = 13'($urandom_range(0, span - 1));
        issue(op, {hi, fold}, 8'($urandom), li);
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end

    wait_drained();
    if (sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
